// ===== rtl/cidt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cidt_pkg
// Shared types and constants for the CAN identifier dispatch table: rule
// entry layout, stream widths, operation and result kind codes.
// ----------------------------------------------------------------------------
package cidt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int DEST_WIDTH  = 8;
	localparam int ID_W        = 12;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// stream widths, rounded up to whole bytes
	localparam int IN_BITS     = 2 * ID_W + DEST_WIDTH;
	localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 1 + DEST_WIDTH + ID_W;
	localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
	localparam int KIND_W      = 2;

	// full-width mask, used by single-identifier rules
	localparam logic [ID_W-1:0] ID_ALL = 12'h0FFF;

	// input operation codes
	typedef enum logic {
		OP_LINK     = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	// result kind codes
	typedef enum logic [KIND_W-1:0] {
		KIND_LINK = 2'd0,
		KIND_FWD  = 2'd1,
		KIND_DROP = 2'd2
	} kind_t;

	// one stored rule
	typedef struct packed {
		logic [DEST_WIDTH-1:0] dest;
		logic [ID_W-1:0]       mask;
		logic [ID_W-1:0]       match;
	} rule_t;

endpackage
`default_nettype wire

// ===== rtl/can_id_mask_dispatch_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// can_id_mask_dispatch_table_unit
// Routing table for CAN identifiers. A link beat appends a mask/match rule
// with a destination unless the table is full; a dispatch beat walks all stored
// rules in order and emits one forward beat per matching rule, or one drop beat if none match.
// ----------------------------------------------------------------------------
// Link: the beat passes through the LINK state, which registers the result
// beat once the output is free; the next beat is taken back in the idle state.
// Dispatch: the single compare unit walks one rule per cycle out of the rule
// memory unless the output stalls; no new beat is taken until the walk ends.
// Reset clears the rule count and all control state; rule storage is left as
// is and needs no clearing pass, since only entries below the count are read.
// ----------------------------------------------------------------------------
module can_id_mask_dispatch_table_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// input stream
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// tdata: id [11:0], mask [23:12], dest [31:24]
	input  wire  [cidt_pkg::IN_DATA_W-1:0]       s_tdata,
	// tuser: op
	input  wire                                  s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// tdata: ok [0], dest_out [8:1], id_out [20:9], zero padding above
	output logic [cidt_pkg::OUT_DATA_W-1:0]      m_tdata,
	// tuser: kind
	output logic [cidt_pkg::KIND_W-1:0]          m_tuser,
	output logic                                 m_tlast
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LINK  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	typedef logic [cidt_pkg::OUT_DATA_W-1:0] out_data_t;

	localparam int DW = cidt_pkg::DEST_WIDTH;
	localparam int IW = cidt_pkg::ID_W;
	localparam int XW = cidt_pkg::IDX_W;
	localparam int CW = cidt_pkg::CNT_W;

	// control state
	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [XW-1:0]   idx_q;
	logic            pend_valid_q;
	logic            out_valid_q;

	// payload registers
	logic [IW-1:0]   id_q;
	logic            link_ok_q;
	logic [DW-1:0]   pend_dest_q;
	logic [cidt_pkg::KIND_W-1:0] out_kind_q;
	logic            out_ok_q;
	logic [DW-1:0]   out_dest_q;
	logic [IW-1:0]   out_id_q;
	logic            out_last_q;

	// rule memory
	cidt_pkg::rule_t mem [cidt_pkg::TABLE_DEPTH];
	cidt_pkg::rule_t rd_q;
	cidt_pkg::rule_t wr_rule;
	logic            wr_en;
	logic            rd_en;
	logic [XW-1:0]   rd_addr;

	// input fields
	logic [IW-1:0]   in_id;
	logic [IW-1:0]   in_mask;
	logic [DW-1:0]   in_dest;
	logic            in_acc;
	logic            table_full;

	// sequencer signals
	logic            out_free;
	logic            hit;
	logic            more;
	logic [CW-1:0]   idx_next;
	logic            emit;
	logic [cidt_pkg::KIND_W-1:0] emit_kind;
	logic            emit_ok;
	logic [DW-1:0]   emit_dest;
	logic [IW-1:0]   emit_id;
	logic            emit_last;
	logic            pend_load;
	logic            pend_clear;
	logic            idx_step;

	// unpack the input beat
	assign in_id      = s_tdata[IW-1:0];
	assign in_mask    = s_tdata[2*IW-1:IW];
	assign in_dest    = s_tdata[2*IW+DW-1:2*IW];
	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid & s_tready;
	assign table_full = (count_q == CW'(cidt_pkg::TABLE_DEPTH));

	assign wr_rule.match = in_id;
	assign wr_rule.mask  = in_mask;
	assign wr_rule.dest  = in_dest;
	assign wr_en = in_acc & (s_tuser == cidt_pkg::OP_LINK) & ~table_full;

	// rule memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[XW-1:0]] <= wr_rule;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// shared compare unit and walk bookkeeping
	assign out_free = ~out_valid_q | m_tready;
	assign hit      = ((id_q & rd_q.mask) == rd_q.match);
	assign idx_next = CW'(idx_q) + CW'(1);
	assign more     = (idx_next < count_q);

	// sequencer
	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		emit_kind  = cidt_pkg::KIND_LINK;
		emit_ok    = 1'b1;
		emit_dest  = '0;
		emit_id    = '0;
		emit_last  = 1'b1;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = idx_q;
		idx_step   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser == cidt_pkg::OP_LINK) begin
						state_d = ST_LINK;
					end else if (count_q == '0) begin
						state_d = ST_FLUSH;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_LINK: begin
				emit_ok = link_ok_q;
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				emit_kind = cidt_pkg::KIND_FWD;
				emit_dest = pend_dest_q;
				emit_id   = id_q;
				emit_last = 1'b0;
				// a new hit pushes out the previous one, which is then not last
				if (!(hit && pend_valid_q && !out_free)) begin
					if (hit) begin
						emit      = pend_valid_q;
						pend_load = 1'b1;
					end
					if (more) begin
						rd_en    = 1'b1;
						rd_addr  = idx_next[XW-1:0];
						idx_step = 1'b1;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				emit_id   = id_q;
				emit_kind = pend_valid_q ? cidt_pkg::KIND_FWD : cidt_pkg::KIND_DROP;
				emit_dest = pend_valid_q ? pend_dest_q : '0;
				if (out_free) begin
					emit       = 1'b1;
					pend_clear = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (in_acc) begin
				idx_q <= '0;
			end else if (idx_step) begin
				idx_q <= idx_next[XW-1:0];
			end
			if (pend_clear) begin
				pend_valid_q <= 1'b0;
			end else if (pend_load) begin
				pend_valid_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q      <= in_id;
			link_ok_q <= ~table_full;
		end
		if (pend_load) begin
			pend_dest_q <= rd_q.dest;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_ok_q   <= emit_ok;
			out_dest_q <= emit_dest;
			out_id_q   <= emit_id;
			out_last_q <= emit_last;
		end
	end

	// result beat
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = out_data_t'({out_id_q, out_dest_q, out_ok_q});

endmodule
`default_nettype wire
